### rtl/core/ipv4_option_type_matcher_core_assert.svh
// Assertion macros for the IPv4 option type matcher.
// Included by the checker; expects signals named clock and reset in scope.
`ifndef IPV4_OPTION_TYPE_MATCHER_CORE_ASSERT_SVH
`define IPV4_OPTION_TYPE_MATCHER_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define OTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define OTM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/ipv4om_pkg.sv
// Shared types and constants for the IPv4 option type matcher.
// No dependencies.
package ipv4om_pkg;

   localparam int LIST_LEN_DEF = 4;   // default list length
   localparam int MAX_OPTIONS  = 40;  // soft mode option limit
   localparam int LIST_SLOTS   = 4;   // entries held by the match type register
   localparam int TYPE_W       = 8;
   localparam int LC_W         = 3;   // list_count register width
   localparam int LIST_W       = 32;  // match type register width
   localparam int OPT_CNT_W    = 6;
   localparam int CNT_SAT      = 63;  // option counters saturate here
   localparam int SKIP_W       = 8;
   localparam int CSR_IDX_W    = 2;

   localparam logic [TYPE_W-1:0] OPT_EOL = 8'd0;
   localparam logic [TYPE_W-1:0] OPT_NOP = 8'd1;
   localparam logic [TYPE_W-1:0] LEN_MIN = 8'd2;

   typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_SKIP, PH_END} walk_phase_type;
   typedef enum logic [1:0] {OC_OPEN, OC_MATCH, OC_FAIL} outcome_type;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOFT_MODE, CSR_INVERT, CSR_LIST_COUNT, CSR_MATCH_TYPES
   } csr_index_type;

   typedef struct packed {
      logic              soft_mode;
      logic              invert;
      logic [LC_W-1:0]   list_count;
      logic [LIST_W-1:0] match_types;
   } csr_type;

   typedef struct packed {
      logic [TYPE_W-1:0] opt_byte;
      logic              byte_present;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic close;    // item ends the packet
      logic verdict;  // final verdict, invert applied
   } walk_out_type;

endpackage

### rtl/core/ipv4om_walk.sv
// Option walker: per-packet state and the per-byte update.
// Depends on ipv4om_pkg.
module ipv4om_walk import ipv4om_pkg::*; #(
   parameter int LIST_LEN = LIST_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  csr_type      csr,
   output walk_out_type result
);

   localparam int CNT_W = $clog2(LIST_LEN + 1);
   localparam int LCX_W = LC_W + 1;

   walk_phase_type         phase_ff, phase_in, phase_b;
   logic [SKIP_W-1:0]      skip_ff, skip_in, skip_b;
   logic [OPT_CNT_W-1:0]   seen_ff, seen_in, seen_b;
   logic [OPT_CNT_W-1:0]   total_ff, total_in, total_b;
   logic [CNT_W-1:0]       seq_ff, seq_in, seq_b;
   outcome_type            outcome_ff, outcome_in, outcome_b;

   logic [TYPE_W-1:0]      entry [LIST_LEN];
   logic [CNT_W-1:0]       used_cnt;
   logic [LCX_W-1:0]       lc_ext;
   logic                   in_list;
   logic [TYPE_W-1:0]      seq_entry;
   logic                   close;
   logic                   hit;

   // entries past the register read as type 0
   for (genvar i = 0; i < LIST_LEN; i++) begin : g_entry
      if (i < LIST_SLOTS) begin : g_reg
         assign entry[i] = csr.match_types[TYPE_W*i +: TYPE_W];
      end else begin : g_zero
         assign entry[i] = '0;
      end
   end

   assign lc_ext   = {1'b0, csr.list_count};
   assign used_cnt = (lc_ext > LCX_W'(LIST_LEN)) ? CNT_W'(LIST_LEN) : CNT_W'(lc_ext);
   assign close    = !item.byte_present || item.last_byte;

   always_comb begin
      in_list   = 1'b0;
      seq_entry = '0;
      for (int i = 0; i < LIST_LEN; i++) begin
         if (CNT_W'(i) < used_cnt && entry[i] == item.opt_byte) in_list = 1'b1;
         if (seq_ff == CNT_W'(i)) seq_entry = entry[i];
      end
   end

   // next state: effect of the byte, then packet clear on close
   always_comb begin
      phase_b   = phase_ff;
      skip_b    = skip_ff;
      seen_b    = seen_ff;
      total_b   = total_ff;
      seq_b     = seq_ff;
      outcome_b = outcome_ff;
      if (item.byte_present) begin
         case (phase_ff)
            PH_TYPE: begin
               if (csr.soft_mode && seen_ff >= OPT_CNT_W'(MAX_OPTIONS)) begin
                  phase_b = PH_END;
               end else begin
                  if (seen_ff != OPT_CNT_W'(CNT_SAT)) seen_b = seen_ff + 1'b1;
                  if (csr.soft_mode) begin
                     if (in_list && total_ff != OPT_CNT_W'(CNT_SAT)) begin
                        total_b = total_ff + 1'b1;
                     end
                  end else if (outcome_ff == OC_OPEN) begin
                     if (seq_ff >= used_cnt) begin
                        outcome_b = OC_MATCH;
                     end else if (seq_entry != item.opt_byte) begin
                        outcome_b = OC_FAIL;
                     end else begin
                        seq_b = seq_ff + 1'b1;
                        if (seq_b >= used_cnt) outcome_b = OC_MATCH;
                     end
                  end
                  phase_b = (item.opt_byte == OPT_EOL || item.opt_byte == OPT_NOP) ?
                            PH_TYPE : PH_LEN;
               end
            end
            PH_LEN: begin
               if (item.opt_byte < LEN_MIN) begin
                  phase_b = PH_END;
               end else if (item.opt_byte == LEN_MIN) begin
                  phase_b = PH_TYPE;
               end else begin
                  skip_b  = item.opt_byte - LEN_MIN;
                  phase_b = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (skip_ff != '0) skip_b = skip_ff - 1'b1;
               if (skip_b == '0) phase_b = PH_TYPE;
            end
            default: begin
            end
         endcase
      end

      if (close) begin
         phase_in   = PH_TYPE;
         skip_in    = '0;
         seen_in    = '0;
         total_in   = '0;
         seq_in     = '0;
         outcome_in = OC_OPEN;
      end else begin
         phase_in   = phase_b;
         skip_in    = skip_b;
         seen_in    = seen_b;
         total_in   = total_b;
         seq_in     = seq_b;
         outcome_in = outcome_b;
      end
   end

   // verdict from the state after this byte
   always_comb begin
      if (seen_b == '0) begin
         hit = 1'b0;
      end else if (csr.soft_mode) begin
         hit = (total_b == OPT_CNT_W'(used_cnt));
      end else begin
         case (outcome_b)
            OC_MATCH: hit = 1'b1;
            OC_FAIL:  hit = 1'b0;
            default:  hit = (seq_b >= used_cnt);
         endcase
      end
      result.close   = close;
      result.verdict = hit ^ csr.invert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         skip_ff    <= '0;
         seen_ff    <= '0;
         total_ff   <= '0;
         seq_ff     <= '0;
         outcome_ff <= OC_OPEN;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         seen_ff    <= seen_in;
         total_ff   <= total_in;
         seq_ff     <= seq_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule

### rtl/core/ipv4_option_type_matcher_core.sv
// Top level of the IPv4 option type matcher.
// Depends on ipv4om_pkg and ipv4om_walk.
//
// Usage:
//  - req_ channel: one byte of the IPv4 options area per item, in packet order.
//    req_last_byte marks the final byte; an item with req_byte_present low
//    closes the packet without a byte (an empty area, or an early close).
//  - rsp_ channel: one verdict item per closed packet, none for other bytes.
//  - csr_ port: write-only soft mode, invert, list count and match types
//    registers, to be written only while no item is in flight (not enforced).
//  - Path: a closing item passes the input register, the walker, then the
//    result register before its verdict shows on rsp_.
//  - Throughput: one item per cycle while no closing byte waits for the
//    result slot; the walker update between the registers is combinational.
//  - Stall: a held verdict does not block bytes that close no packet; a
//    closing byte waits in the input register until the result slot frees,
//    and req_ready is low only while it waits.
//  - Reset: clears the registers, the walker state and both valid flags.
module ipv4_option_type_matcher_core import ipv4om_pkg::*; #(
   parameter int LIST_LEN = LIST_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TYPE_W-1:0]    req_opt_byte,
   input  logic                 req_byte_present,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_verdict,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIST_W-1:0]    csr_wdata
);

   csr_type      csr_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_verdict_ff;
   walk_out_type walk_res;
   logic         step;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SOFT_MODE:   csr_ff.soft_mode   <= csr_wdata[0];
            CSR_INVERT:      csr_ff.invert      <= csr_wdata[0];
            CSR_LIST_COUNT:  csr_ff.list_count  <= csr_wdata[LC_W-1:0];
            CSR_MATCH_TYPES: csr_ff.match_types <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // a byte moves through the walker unless it closes a packet
   // while the result slot is still occupied
   assign step      = in_valid_ff && (!walk_res.close || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{opt_byte: req_opt_byte, byte_present: req_byte_present,
                         last_byte: req_last_byte};
      end
   end

   ipv4om_walk #(
      .LIST_LEN(LIST_LEN)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .step_en(step),
      .item   (in_item_ff),
      .csr    (csr_ff),
      .result (walk_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && walk_res.close) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && walk_res.close) out_verdict_ff <= walk_res.verdict;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = out_verdict_ff;

endmodule

### rtl/core/ipv4om_checker.sv
// Port-level checks for the IPv4 option type matcher, bound to the top level.
// Depends on ipv4_option_type_matcher_core_assert.svh.
`include "ipv4_option_type_matcher_core_assert.svh"

module ipv4om_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_byte_present,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_verdict
);

   logic req_close;   // accepted item that ends a packet
   logic rsp_stall;

   assign req_close = req_valid && req_ready && (!req_byte_present || req_last_byte);
   assign rsp_stall = rsp_valid && !rsp_ready;

   `OTM_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "rsp_valid after reset")
   `OTM_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_verdict), "verdict moved")
   `OTM_ASSERT(a_ready_follows, rsp_ready |-> req_ready, "req_ready low while rsp_ready high")
   `OTM_ASSERT(a_close_latency, req_close ##1 rsp_ready |=> rsp_valid, "no verdict for close")

endmodule

bind ipv4_option_type_matcher_core ipv4om_checker u_checker (.*);
